>>> rtl/core/mcar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcar_pkg
// shared types, codes and helpers of the mesh route computation unit
// ----------------------------------------------------------------------------
package mcar_pkg;

  localparam int COORD_W = 3;
  localparam int DIR_W   = 2;
  localparam int VAL_W   = 8;
  localparam int COST_W  = 12;
  localparam int PORT_W  = 3;
  localparam int MODE_W  = 2;

  localparam logic [COST_W-1:0] COST_MAX = 12'hFFF;

  localparam logic [PORT_W-1:0] PORT_LOCAL = 3'd0;
  localparam logic [PORT_W-1:0] PORT_EAST  = 3'd1;
  localparam logic [PORT_W-1:0] PORT_SOUTH = 3'd2;
  localparam logic [PORT_W-1:0] PORT_WEST  = 3'd3;
  localparam logic [PORT_W-1:0] PORT_NORTH = 3'd4;

  localparam logic [DIR_W-1:0] DIR_EAST  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
  localparam logic [DIR_W-1:0] DIR_WEST  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_NORTH = 2'd3;

  localparam logic [MODE_W-1:0] MODE_DOR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GREEDY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DP     = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_X,
    ST_RD_Y,
    ST_CELL,
    ST_GREEDY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] node_x;
    logic [COORD_W-1:0] node_y;
    logic [DIR_W-1:0]   link_dir;
    logic [VAL_W-1:0]   link_value;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } item_t;

  typedef struct packed {
    logic [PORT_W-1:0] out_port;
    logic [COST_W-1:0] path_cost;
  } res_t;

  function automatic logic [PORT_W-1:0] route_dor(input logic [COORD_W-1:0] cx,
                                                   input logic [COORD_W-1:0] cy,
                                                   input logic [COORD_W-1:0] dx,
                                                   input logic [COORD_W-1:0] dy);
    logic [PORT_W-1:0] p;
    if (dx > cx) p = PORT_EAST;
    else if (dx < cx) p = PORT_WEST;
    else if (dy > cy) p = PORT_NORTH;
    else if (dy < cy) p = PORT_SOUTH;
    else p = PORT_LOCAL;
    return p;
  endfunction

endpackage

>>> rtl/core/mcar_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcar_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module mcar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/mcar_cost_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcar_cost_unit
// shared saturating add of a link cost and compare against a running best
// ----------------------------------------------------------------------------
module mcar_cost_unit
  import mcar_pkg::*;
(
  input  logic [COST_W-1:0] acc,
  input  logic [VAL_W-1:0]  link,
  input  logic [COST_W-1:0] ref_cost,
  output logic [COST_W-1:0] sum,
  output logic              less
);

  logic [COST_W:0] raw;

  always_comb begin
    raw  = {1'b0, acc} + {{(COST_W + 1 - VAL_W){1'b0}}, link};
    sum  = raw[COST_W] ? COST_MAX : raw[COST_W-1:0];
    less = sum < ref_cost;
  end

endmodule

>>> rtl/core/mcar_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcar_ctrl
// sequencer: store clear, link writes, greedy lookup and the cell-by-cell
// dynamic program over the route rectangle
// ----------------------------------------------------------------------------
module mcar_ctrl
  import mcar_pkg::*;
#(
  parameter int MESH_X = 8,
  parameter int MESH_Y = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [MODE_W-1:0]                      mode,
  input  logic                                   start,
  input  item_t                                  item,
  output logic                                   ready,
  output logic                                   res_valid,
  output res_t                                   res,
  input  logic                                   out_ready,
  output logic                                   link_we,
  output logic [$clog2(MESH_X*MESH_Y*4)-1:0]     link_addr,
  output logic [VAL_W-1:0]                       link_wdata,
  input  logic [VAL_W-1:0]                       link_rdata,
  output logic                                   dp_we,
  output logic [$clog2(MESH_X*MESH_Y)-1:0]       dp_addr,
  output logic [COST_W-1:0]                      dp_wdata,
  input  logic [COST_W-1:0]                      dp_rdata,
  output logic [COST_W-1:0]                      cu_acc,
  output logic [VAL_W-1:0]                       cu_link,
  output logic [COST_W-1:0]                      cu_ref,
  input  logic [COST_W-1:0]                      cu_sum,
  input  logic                                   cu_less
);

  localparam int NW     = $clog2(MESH_X * MESH_Y);
  localparam int LW     = $clog2(MESH_X * MESH_Y * 4);
  localparam int LDEPTH = MESH_X * MESH_Y * 4;

  function automatic logic [NW-1:0] node_idx(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
    logic [NW+COORD_W:0] t;
    t = (NW + COORD_W + 1)'(x) * (NW + COORD_W + 1)'(MESH_Y) + (NW + COORD_W + 1)'(y);
    return t[NW-1:0];
  endfunction

  state_t state, state_next;

  logic [LW-1:0]      clr_addr;
  logic [COORD_W-1:0] cx, cy, dx, dy, i, j;
  logic               east, north, is_dp;
  logic [COST_W-1:0]  xsum, prev;
  logic [VAL_W-1:0]   lx;
  logic [PORT_W-1:0]  best, res_port;
  logic [COST_W-1:0]  res_cost;

  logic               q_in_range, w_in_range, same, axis;
  logic               have_x, have_y, last_cell;
  logic [COORD_W-1:0] i_nb;
  logic [PORT_W-1:0]  xport, yport, cell_port;
  logic [DIR_W-1:0]   xdir, ydir;
  logic [COST_W-1:0]  minc;

  always_comb begin
    w_in_range = ({2'b0, item.node_x} < 5'(MESH_X)) && ({2'b0, item.node_y} < 5'(MESH_Y));
    q_in_range = w_in_range && ({2'b0, item.dest_x} < 5'(MESH_X)) &&
                 ({2'b0, item.dest_y} < 5'(MESH_Y));
    same       = (item.node_x == item.dest_x) && (item.node_y == item.dest_y);
    axis       = (item.node_x == item.dest_x) || (item.node_y == item.dest_y);
    xport      = east ? PORT_EAST : PORT_WEST;
    yport      = north ? PORT_NORTH : PORT_SOUTH;
    xdir       = east ? DIR_EAST : DIR_WEST;
    ydir       = north ? DIR_NORTH : DIR_SOUTH;
    i_nb       = east ? i + 3'd1 : i - 3'd1;
    have_x     = i != dx;
    have_y     = j != dy;
    last_cell  = (i == cx) && (j == cy);
    // y path wins only when strictly cheaper, so ties stay east or west
    if (!have_x && !have_y) begin
      minc      = '0;
      cell_port = best;
    end else if (have_x && (!have_y || !cu_less)) begin
      minc      = xsum;
      cell_port = xport;
    end else begin
      minc      = cu_sum;
      cell_port = yport;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LW'(LDEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && item.opcode == OP_ROUTE) begin
          if (q_in_range && !same &&
              ((mode == MODE_GREEDY && !axis) || mode == MODE_DP)) begin
            state_next = ST_RD_X;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RD_X:   state_next = ST_RD_Y;
      ST_RD_Y:   state_next = is_dp ? ST_CELL : ST_GREEDY;
      ST_GREEDY: state_next = ST_DONE;
      ST_CELL:   state_next = last_cell ? ST_DONE : ST_RD_X;
      ST_DONE: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    ready      = 1'b0;
    res_valid  = 1'b0;
    link_we    = 1'b0;
    link_addr  = '0;
    link_wdata = '0;
    dp_we      = 1'b0;
    dp_addr    = '0;
    dp_wdata   = minc;
    cu_acc     = '0;
    cu_link    = '0;
    cu_ref     = '0;
    case (state)
      ST_CLEAR: begin
        link_we   = 1'b1;
        link_addr = clr_addr;
      end
      ST_IDLE: begin
        ready      = 1'b1;
        link_we    = start && item.opcode == OP_WRITE && w_in_range;
        link_addr  = {node_idx(item.node_x, item.node_y), item.link_dir};
        link_wdata = item.link_value;
      end
      ST_RD_X: begin
        link_addr = {node_idx(i, j), xdir};
        if (have_x) dp_addr = node_idx(i_nb, j);
      end
      ST_RD_Y: begin
        link_addr = {node_idx(i, j), ydir};
        cu_acc    = dp_rdata;
        cu_link   = link_rdata;
      end
      ST_CELL: begin
        dp_we   = 1'b1;
        dp_addr = node_idx(i, j);
        cu_acc  = prev;
        cu_link = link_rdata;
        cu_ref  = xsum;
      end
      ST_GREEDY: begin
        cu_link = lx;
        cu_ref  = {{(COST_W - VAL_W){1'b0}}, link_rdata};
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

  assign res.out_port  = res_port;
  assign res.path_cost = res_cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          cx       <= item.node_x;
          cy       <= item.node_y;
          dx       <= item.dest_x;
          dy       <= item.dest_y;
          east     <= item.dest_x > item.node_x;
          north    <= item.dest_y > item.node_y;
          is_dp    <= mode == MODE_DP;
          i        <= (mode == MODE_DP) ? item.dest_x : item.node_x;
          j        <= (mode == MODE_DP) ? item.dest_y : item.node_y;
          best     <= PORT_LOCAL;
          res_cost <= '0;
          res_port <= (q_in_range && (mode == MODE_DOR || mode == MODE_GREEDY)) ?
                      route_dor(item.node_x, item.node_y, item.dest_x, item.dest_y) :
                      PORT_LOCAL;
        end
      end
      ST_RD_Y: begin
        xsum <= cu_sum;
        lx   <= link_rdata;
      end
      ST_GREEDY: begin
        res_port <= cu_less ? xport : yport;
      end
      ST_CELL: begin
        prev <= minc;
        best <= cell_port;
        if (last_cell) begin
          res_port <= cell_port;
          res_cost <= minc;
        end else if (j == cy) begin
          i <= east ? i - 3'd1 : i + 3'd1;
          j <= dy;
        end else begin
          j <= north ? j - 3'd1 : j + 3'd1;
        end
      end
      default: begin
        prev <= prev;
      end
    endcase
  end

endmodule

>>> rtl/core/mesh_congestion_aware_router.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_congestion_aware_router
// route computation for a 2d mesh with a per-link congestion store
// ----------------------------------------------------------------------------
// input stream: tuser is the opcode; a write transaction loads one link cost
// and finishes in the cycle it is accepted, producing no result. a route
// transaction produces exactly one result on the output stream.
// for a route query, dimension order, local answers and greedy queries along
// one axis go straight to the output register; greedy first compares the x
// and y link costs; the dynamic program visits each cell of the
// current-to-destination rectangle, reading its x and y links in turn
// through the single read port of the link cost ram shared by both lookups.
// one query is in work at a time and s_axis_tready is low meanwhile.
// after reset the link cost ram is swept to zero, all MESH_X*MESH_Y*4 entries
// (256 on an 8x8 mesh), with s_axis_tready low; routing_mode resets to 0.
// a result waits in the output register while m_axis_tready is low; link
// writes and one more route query may be taken; that result then waits
// for the register. routing_mode is written through cfg_wr_en / cfg_wr_data.
// ----------------------------------------------------------------------------
module mesh_congestion_aware_router
  import mcar_pkg::*;
#(
  parameter int MESH_X = 8,
  parameter int MESH_Y = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // node_x[2:0] node_y[5:3] link_dir[7:6] link_value[15:8] dest_x[18:16] dest_y[21:19]
  input  logic [23:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_port[2:0] path_cost[14:3]
  output logic [15:0] m_axis_tdata
);

  localparam int NDEPTH = MESH_X * MESH_Y;
  localparam int LDEPTH = MESH_X * MESH_Y * 4;

  logic [MODE_W-1:0] mode;
  item_t             item;
  res_t              res;
  logic              start, ready, res_valid, out_ready;

  logic                      link_we;
  logic [$clog2(LDEPTH)-1:0] link_addr;
  logic [VAL_W-1:0]          link_wdata, link_rdata;
  logic                      dp_we;
  logic [$clog2(NDEPTH)-1:0] dp_addr;
  logic [COST_W-1:0]         dp_wdata, dp_rdata;
  logic [COST_W-1:0]         cu_acc, cu_ref, cu_sum;
  logic [VAL_W-1:0]          cu_link;
  logic                      cu_less;

  always_comb begin
    item.opcode     = s_axis_tuser;
    item.node_x     = s_axis_tdata[2:0];
    item.node_y     = s_axis_tdata[5:3];
    item.link_dir   = s_axis_tdata[7:6];
    item.link_value = s_axis_tdata[15:8];
    item.dest_x     = s_axis_tdata[18:16];
    item.dest_y     = s_axis_tdata[21:19];
  end

  assign s_axis_tready = ready;
  assign start         = s_axis_tvalid && ready;
  assign out_ready     = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DOR;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && out_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_ready) begin
      m_axis_tdata <= {1'b0, res.path_cost, res.out_port};
    end
  end

  mcar_ram #(.WIDTH(VAL_W), .DEPTH(LDEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .addr  (link_addr),
    .wdata (link_wdata),
    .rdata (link_rdata)
  );

  mcar_ram #(.WIDTH(COST_W), .DEPTH(NDEPTH)) u_dp_ram (
    .clk   (clk),
    .we    (dp_we),
    .addr  (dp_addr),
    .wdata (dp_wdata),
    .rdata (dp_rdata)
  );

  mcar_cost_unit u_cost (
    .acc      (cu_acc),
    .link     (cu_link),
    .ref_cost (cu_ref),
    .sum      (cu_sum),
    .less     (cu_less)
  );

  mcar_ctrl #(.MESH_X(MESH_X), .MESH_Y(MESH_Y)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .start      (start),
    .item       (item),
    .ready      (ready),
    .res_valid  (res_valid),
    .res        (res),
    .out_ready  (out_ready),
    .link_we    (link_we),
    .link_addr  (link_addr),
    .link_wdata (link_wdata),
    .link_rdata (link_rdata),
    .dp_we      (dp_we),
    .dp_addr    (dp_addr),
    .dp_wdata   (dp_wdata),
    .dp_rdata   (dp_rdata),
    .cu_acc     (cu_acc),
    .cu_link    (cu_link),
    .cu_ref     (cu_ref),
    .cu_sum     (cu_sum),
    .cu_less    (cu_less)
  );

  // a local answer never carries a path cost
  a_local_zero_cost: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == PORT_LOCAL |-> m_axis_tdata[14:3] == '0)
    else $error("local result with nonzero path cost");

  // the store sweep keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready)
    else $error("input ready during store clear");

  // a route query always keeps the sequencer busy in the cycle after it is accepted
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ROUTE |=> !s_axis_tready)
    else $error("ready right after a route query");

endmodule
